// ===== src/fcks_pkg.sv =====
// fcks_pkg: shared widths, register indexes, reset values and item types
// for the fan curve with kick start block. No dependencies.
`timescale 1ns / 1ps

package fcks_pkg;

    // field widths
    localparam int TEMP_W   = 12;
    localparam int DUTY_W   = 7;
    localparam int NOW_W    = 32;
    localparam int STICK_W  = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // timestamp arithmetic wraps at this many bits (16 to 64)
    localparam int TICK_BITS = 32;

    // ramp unit widths: product of temperature span and duty span,
    // pre-shifted divisor, shared adder and step counter
    localparam int PROD_W = TEMP_W + DUTY_W;
    localparam int DSR_W  = TEMP_W + DUTY_W - 1;
    localparam int ALU_W  = PROD_W + 1;
    localparam int STEP_W = $clog2(DUTY_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_TEMP       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_TEMP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DUTY  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MODE     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_MODE   = CFG_IDX_W'(7);

    // register reset values
    localparam logic signed [TEMP_W-1:0] RST_ON_TEMP   = TEMP_W'(320);
    localparam logic signed [TEMP_W-1:0] RST_FULL_TEMP = TEMP_W'(1120);
    localparam logic [DUTY_W-1:0]  RST_DUTY_MIN      = DUTY_W'(35);
    localparam logic [DUTY_W-1:0]  RST_DUTY_MAX      = DUTY_W'(100);
    localparam logic [DUTY_W-1:0]  RST_STARTUP_DUTY  = DUTY_W'(100);
    localparam logic [STICK_W-1:0] RST_STARTUP_TICKS = STICK_W'(120);
    localparam logic [DUTY_W-1:0]  RST_HIGH_MODE     = DUTY_W'(70);
    localparam logic [DUTY_W-1:0]  RST_MEDIUM_MODE   = DUTY_W'(40);

    // fan modes
    localparam logic [MODE_W-1:0] MODE_OFF    = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_LOW    = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MEDIUM = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_HIGH   = MODE_W'(3);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [NOW_W-1:0]         now_tick;
    } sample_t;

    typedef struct packed {
        logic [MODE_W-1:0] fan_mode;
        logic [DUTY_W-1:0] duty_percent;
    } result_t;

    // request to the ramp unit
    typedef struct packed {
        logic                     start;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [TEMP_W-1:0] on_temp;
        logic signed [TEMP_W-1:0] full_temp;
        logic [DUTY_W-1:0]        duty_min;
        logic [DUTY_W-1:0]        duty_max;
    } ramp_op_t;

    // status back from the ramp unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DUTY_W-1:0] duty;
    } ramp_rsp_t;

endpackage

// ===== src/fcks_ramp.sv =====
// fcks_ramp: ramp duty = duty_min + floor((t - on) * (max - min) / (full - on))
// on one shared adder: shift-add multiply, then restoring divide. Uses fcks_pkg.
`timescale 1ns / 1ps

module fcks_ramp
    import fcks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ramp_op_t  op,
    output ramp_rsp_t rsp
);

    typedef enum logic [2:0] {
        R_IDLE,
        R_SUBX,
        R_SUBD,
        R_SUBM,
        R_MUL,
        R_DIV,
        R_ADD
    } ramp_state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DUTY_W - 1);

    ramp_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [TEMP_W-1:0]  x_reg,     x_next;
    logic [DUTY_W-1:0]  mul_reg,   mul_next;
    logic [PROD_W-1:0]  acc_reg,   acc_next;
    logic [DSR_W-1:0]   dsr_reg,   dsr_next;
    logic [DUTY_W-1:0]  q_reg,     q_next;
    logic [DUTY_W-1:0]  duty_reg,  duty_next;
    logic               done_reg,  done_next;

    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic               alu_sub;
    logic [ALU_W-1:0]   alu_sum;

    // the one shared adder / subtractor
    assign alu_sum = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            R_IDLE:
            begin
                alu_a = '0;
            end
            R_SUBX:
            begin
                alu_a   = {{(ALU_W-TEMP_W){op.temperature[TEMP_W-1]}}, op.temperature};
                alu_b   = {{(ALU_W-TEMP_W){op.on_temp[TEMP_W-1]}}, op.on_temp};
                alu_sub = 1'b1;
            end
            R_SUBD:
            begin
                alu_a   = {{(ALU_W-TEMP_W){op.full_temp[TEMP_W-1]}}, op.full_temp};
                alu_b   = {{(ALU_W-TEMP_W){op.on_temp[TEMP_W-1]}}, op.on_temp};
                alu_sub = 1'b1;
            end
            R_SUBM:
            begin
                alu_a   = ALU_W'(op.duty_max);
                alu_b   = ALU_W'(op.duty_min);
                alu_sub = 1'b1;
            end
            R_MUL:
            begin
                alu_a = ALU_W'({acc_reg, 1'b0});
                alu_b = mul_reg[DUTY_W-1] ? ALU_W'(x_reg) : '0;
            end
            R_DIV:
            begin
                alu_a   = ALU_W'(acc_reg);
                alu_b   = ALU_W'(dsr_reg);
                alu_sub = 1'b1;
            end
            R_ADD:
            begin
                alu_a = ALU_W'(op.duty_min);
                alu_b = ALU_W'(q_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        mul_next   = mul_reg;
        acc_next   = acc_reg;
        dsr_next   = dsr_reg;
        q_next     = q_reg;
        duty_next  = duty_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            R_IDLE:
            begin
                if (op.start)
                begin
                    state_next = R_SUBX;
                end
            end
            R_SUBX:
            begin
                x_next     = alu_sum[TEMP_W-1:0];
                state_next = R_SUBD;
            end
            R_SUBD:
            begin
                // divisor aligned to the top quotient bit
                dsr_next   = {alu_sum[TEMP_W-1:0], {(DUTY_W-1){1'b0}}};
                state_next = R_SUBM;
            end
            R_SUBM:
            begin
                mul_next   = alu_sum[DUTY_W-1:0];
                acc_next   = '0;
                step_next  = '0;
                state_next = R_MUL;
            end
            R_MUL:
            begin
                acc_next = alu_sum[PROD_W-1:0];
                mul_next = {mul_reg[DUTY_W-2:0], 1'b0};
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    q_next     = '0;
                    state_next = R_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            R_DIV:
            begin
                if (!alu_sum[ALU_W-1])
                begin
                    acc_next = alu_sum[PROD_W-1:0];
                end
                q_next   = {q_reg[DUTY_W-2:0], ~alu_sum[ALU_W-1]};
                dsr_next = dsr_reg >> 1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = R_ADD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            R_ADD:
            begin
                duty_next  = alu_sum[DUTY_W-1:0];
                done_next  = 1'b1;
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        mul_reg  <= mul_next;
        acc_reg  <= acc_next;
        dsr_reg  <= dsr_next;
        q_reg    <= q_next;
        duty_reg <= duty_next;
    end

    assign rsp.busy = (state_reg != R_IDLE);
    assign rsp.done = done_reg;
    assign rsp.duty = duty_reg;

endmodule

// ===== src/fan_curve_with_kickstart_core.sv =====
// fan_curve_with_kickstart_core: top level of the fan curve block with kick start.
// Depends on fcks_pkg and fcks_ramp.
`timescale 1ns / 1ps

// Usage
//   sample channel: sample_valid / sample_stall carry one item (temperature in
//     signed 1/16 degree C, free-running now_tick). An item is taken at a clock
//     edge with sample_valid high and sample_stall low.
//   result channel: result_valid / result_stall carry one item (fan_mode,
//     duty_percent) for every sample, in order.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index
//     0..7 selects a register, higher indexes are dropped. cfg_ready is always
//     high; write only while no sample is in flight.
// Sequence
//   below on_temp, at or above full_temp, or with a flat curve: the finish
//     state registers the result once the result register is free
//   on the ramp: the shared adder runs 3 subtracts, 7 shift-add multiply steps,
//     7 restoring divide steps and one add, then the finish state registers
//     the result; the block then returns to idle for the next sample
//   sample_stall stays high while an item is processed
// Stall: the result register holds its item under result_stall; the next item
//   is still accepted and computed, and waits for the register to empty.
// Reset: registers return to their default curve, fan is taken as off and any
//   kick start is cancelled.

module fan_curve_with_kickstart_core
    import fcks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,

    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RAMP,
        S_FINISH
    } core_state_t;

    // control
    core_state_t state_reg, state_next;
    logic        start_reg, start_next;
    logic        result_valid_reg, result_valid_next;
    logic        was_off_reg, was_off_next;
    logic        kick_active_reg, kick_active_next;

    // configuration
    logic signed [TEMP_W-1:0] on_temp_reg, on_temp_next;
    logic signed [TEMP_W-1:0] full_temp_reg, full_temp_next;
    logic [DUTY_W-1:0]  duty_min_reg, duty_min_next;
    logic [DUTY_W-1:0]  duty_max_reg, duty_max_next;
    logic [DUTY_W-1:0]  startup_duty_reg, startup_duty_next;
    logic [STICK_W-1:0] startup_ticks_reg, startup_ticks_next;
    logic [DUTY_W-1:0]  high_mode_reg, high_mode_next;
    logic [DUTY_W-1:0]  medium_mode_reg, medium_mode_next;

    // per item
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [TICK_BITS-1:0]     now_reg, now_next;
    logic [TICK_BITS-1:0]     kick_start_reg, kick_start_next;
    logic                     off_reg, off_next;
    logic                     full_reg, full_next;
    logic [DUTY_W-1:0]        curve_reg, curve_next;
    result_t                  result_reg, result_next;

    logic                     accept;
    logic                     is_off;
    logic                     is_full;
    logic                     has_ramp;
    logic                     out_free;
    logic [TICK_BITS-1:0]     elapsed;
    logic [MODE_W-1:0]        mode_fin;
    ramp_op_t                 ramp_op;
    ramp_rsp_t                ramp_rsp;

    assign accept   = sample_valid && (state_reg == S_IDLE);
    assign is_off   = $signed(sample.temperature) < $signed(on_temp_reg);
    assign is_full  = $signed(sample.temperature) >= $signed(full_temp_reg);
    assign has_ramp = !is_off && !is_full && (duty_max_reg > duty_min_reg);
    assign out_free = !result_valid_reg || !result_stall;

    // wrapping time since the kick began
    assign elapsed = now_reg - kick_start_reg;

    assign ramp_op.start       = start_reg;
    assign ramp_op.temperature = temp_reg;
    assign ramp_op.on_temp     = on_temp_reg;
    assign ramp_op.full_temp   = full_temp_reg;
    assign ramp_op.duty_min    = duty_min_reg;
    assign ramp_op.duty_max    = duty_max_reg;

    fcks_ramp u_ramp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (ramp_op),
        .rsp   (ramp_rsp)
    );

    // curve mode; the full branch is always high
    always_comb
    begin
        priority if (full_reg)
        begin
            mode_fin = MODE_HIGH;
        end
        else if (curve_reg >= high_mode_reg)
        begin
            mode_fin = MODE_HIGH;
        end
        else if (curve_reg >= medium_mode_reg)
        begin
            mode_fin = MODE_MEDIUM;
        end
        else
        begin
            mode_fin = MODE_LOW;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        start_next         = 1'b0;
        result_valid_next  = result_valid_reg && result_stall;
        was_off_next       = was_off_reg;
        kick_active_next   = kick_active_reg;
        on_temp_next       = on_temp_reg;
        full_temp_next     = full_temp_reg;
        duty_min_next      = duty_min_reg;
        duty_max_next      = duty_max_reg;
        startup_duty_next  = startup_duty_reg;
        startup_ticks_next = startup_ticks_reg;
        high_mode_next     = high_mode_reg;
        medium_mode_next   = medium_mode_reg;
        temp_next          = temp_reg;
        now_next           = now_reg;
        kick_start_next    = kick_start_reg;
        off_next           = off_reg;
        full_next          = full_reg;
        curve_next         = curve_reg;
        result_next        = result_reg;

        // register writes, value truncated to register width
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ON_TEMP:       on_temp_next       = cfg_data[TEMP_W-1:0];
                REG_FULL_TEMP:     full_temp_next     = cfg_data[TEMP_W-1:0];
                REG_DUTY_MIN:      duty_min_next      = cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX:      duty_max_next      = cfg_data[DUTY_W-1:0];
                REG_STARTUP_DUTY:  startup_duty_next  = cfg_data[DUTY_W-1:0];
                REG_STARTUP_TICKS: startup_ticks_next = cfg_data[STICK_W-1:0];
                REG_HIGH_MODE:     high_mode_next     = cfg_data[DUTY_W-1:0];
                REG_MEDIUM_MODE:   medium_mode_next   = cfg_data[DUTY_W-1:0];
                default:           on_temp_next       = on_temp_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    temp_next  = sample.temperature;
                    now_next   = TICK_BITS'(sample.now_tick);
                    off_next   = is_off;
                    full_next  = is_full;
                    // flat curve clamps to duty_min
                    curve_next = is_full ? duty_max_reg : duty_min_reg;
                    if (has_ramp)
                    begin
                        start_next = 1'b1;
                        state_next = S_RAMP;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_RAMP:
            begin
                if (ramp_rsp.done)
                begin
                    curve_next = ramp_rsp.duty;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                    if (off_reg)
                    begin
                        // fan off cancels the kick
                        was_off_next             = 1'b1;
                        kick_active_next         = 1'b0;
                        result_next.fan_mode     = MODE_OFF;
                        result_next.duty_percent = '0;
                    end
                    else
                    begin
                        result_next.fan_mode     = mode_fin;
                        result_next.duty_percent = curve_reg;
                        if (was_off_reg)
                        begin
                            // first item after off starts the kick
                            was_off_next             = 1'b0;
                            kick_active_next         = 1'b1;
                            kick_start_next          = now_reg;
                            result_next.duty_percent = startup_duty_reg;
                        end
                        else if (kick_active_reg)
                        begin
                            if (elapsed < TICK_BITS'(startup_ticks_reg))
                            begin
                                result_next.duty_percent = startup_duty_reg;
                            end
                            else
                            begin
                                kick_active_next = 1'b0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            start_reg         <= 1'b0;
            result_valid_reg  <= 1'b0;
            was_off_reg       <= 1'b1;
            kick_active_reg   <= 1'b0;
            kick_start_reg    <= '0;
            on_temp_reg       <= RST_ON_TEMP;
            full_temp_reg     <= RST_FULL_TEMP;
            duty_min_reg      <= RST_DUTY_MIN;
            duty_max_reg      <= RST_DUTY_MAX;
            startup_duty_reg  <= RST_STARTUP_DUTY;
            startup_ticks_reg <= RST_STARTUP_TICKS;
            high_mode_reg     <= RST_HIGH_MODE;
            medium_mode_reg   <= RST_MEDIUM_MODE;
        end
        else
        begin
            state_reg         <= state_next;
            start_reg         <= start_next;
            result_valid_reg  <= result_valid_next;
            was_off_reg       <= was_off_next;
            kick_active_reg   <= kick_active_next;
            kick_start_reg    <= kick_start_next;
            on_temp_reg       <= on_temp_next;
            full_temp_reg     <= full_temp_next;
            duty_min_reg      <= duty_min_next;
            duty_max_reg      <= duty_max_next;
            startup_duty_reg  <= startup_duty_next;
            startup_ticks_reg <= startup_ticks_next;
            high_mode_reg     <= high_mode_next;
            medium_mode_reg   <= medium_mode_next;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        temp_reg   <= temp_next;
        now_reg    <= now_next;
        off_reg    <= off_next;
        full_reg   <= full_next;
        curve_reg  <= curve_next;
        result_reg <= result_next;
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

`ifndef NO_ASSERTIONS
    // the ramp unit only runs while an item is held
    a_ramp_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_stall |-> !ramp_rsp.busy)
        else $error("ramp unit busy while accepting samples");

    // a ramp result only lands while waiting for it
    a_done_in_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_rsp.done |-> (state_reg == S_RAMP))
        else $error("ramp result outside ramp wait");

    // a new result appears only from the finish step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish step");

    // kick never runs while the fan is taken as off
    a_kick_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
        kick_active_reg |-> !was_off_reg)
        else $error("kick active while fan marked off");

    // off mode always carries zero duty
    a_off_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.fan_mode == MODE_OFF)) |-> (result.duty_percent == '0))
        else $error("off result with nonzero duty");
`endif

endmodule
